@@ sv/ola_pkg.sv @@
// Shared types and constants for the ordered array list engine.
// No dependencies; imported by ola_cell and ordered_array_list_engine.
`timescale 1ns / 1ps

package ola_pkg;

  // Default build sizes
  localparam int DEPTH_DEF       = 16;
  localparam int ENTRY_WIDTH_DEF = 32;

  // Fixed port widths
  localparam int POS_W   = 5;
  localparam int VAL_W   = 32;
  localparam int CFG_W   = 5;
  localparam int STAT_W  = 3;
  localparam int COUNT_W = 5;

  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    OP_INSERT    = 2'd0,
    OP_ERASE_POS = 2'd1,
    OP_ERASE_VAL = 2'd2
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_BAD_POS   = 3'd2,
    STAT_EMPTY     = 3'd3,
    STAT_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ACT_HOLD,
    ACT_MARK,
    ACT_SCAN,
    ACT_INSERT,
    ACT_ERASE_POS,
    ACT_ERASE_VAL
  } action_t;

  // Broadcast to every cell each cycle
  typedef struct packed {
    action_t action;
    logic    found;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MARK,
    S_SCAN,
    S_APPLY
  } state_t;

endpackage

@@ sv/ordered_array_list_engine.sv @@
// Ordered array list engine: a positional list held in a row of cells (ola_pkg, ola_cell).
// Flow: an accepted operation goes from S_IDLE to S_APPLY; an erase by value first passes
// S_MARK (the compare) and S_SCAN (the suffix-OR scan across the cells). out_valid is registered.
// Throughput: one item in flight; the next transfer waits for the return to S_IDLE,
// and S_APPLY waits longer while a result is held by out_ready.
// Reset clears the count and sets the capacity to 16; entry storage is not reset.
`timescale 1ns / 1ps

module ordered_array_list_engine
  import ola_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_we,
  input  logic [CFG_W-1:0]   cfg_wdata,
  // operation channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         opcode,
  input  logic [POS_W-1:0]   position,
  input  logic [VAL_W-1:0]   value,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [STAT_W-1:0]  status,
  output logic [COUNT_W-1:0] count,
  output logic               is_empty
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CW    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int STEPS = $clog2(DEPTH);
  localparam int SW    = (STEPS > 1) ? $clog2(STEPS) : 1;

  // Control state
  state_t           state, state_next;
  logic [SW-1:0]    step;
  logic [CNT_W-1:0] used_count;
  logic [CFG_W-1:0] capacity_limit;

  // Operation held for the duration of its work
  logic [1:0]             op_q;
  logic [CW-1:0]          pos_q;
  logic [ENTRY_WIDTH-1:0] val_q;

  // Result register
  logic [STAT_W-1:0]  status_q;
  logic [COUNT_W-1:0] count_q;
  logic               empty_q;

  // Apply-cycle decision
  status_t          status_next;
  logic [CNT_W-1:0] used_next;
  action_t          apply_act;
  logic             out_free;
  logic             apply_go;

  logic [CW-1:0] used_ext;
  logic [CW-1:0] cap_ext;
  logic [CW-1:0] eff_cap;

  cell_ctrl_t ctrl;

  logic [ENTRY_WIDTH-1:0] cell_entry [DEPTH];
  logic [2*DEPTH-1:0]     mark_ext;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign apply_go = (state == S_APPLY) && out_free;

  // Configuration: take the write at once, no handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= CAP_RESET;
    end else if (cfg_we) begin
      capacity_limit <= cfg_wdata;
    end
  end

  // Hold the accepted operation
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q  <= opcode;
      pos_q <= CW'(position);
      val_q <= ENTRY_WIDTH'(value);
    end
  end

  // Clamp the capacity to 1..DEPTH
  assign used_ext = CW'(used_count);
  assign cap_ext  = CW'(capacity_limit);
  always_comb begin
    if (cap_ext == '0) begin
      eff_cap = CW'(1);
    end else if (cap_ext > CW'(DEPTH)) begin
      eff_cap = CW'(DEPTH);
    end else begin
      eff_cap = cap_ext;
    end
  end

  // Decide the outcome; errors leave the list untouched
  always_comb begin
    status_next = STAT_OK;
    used_next   = used_count;
    apply_act   = ACT_HOLD;
    unique case (op_q)
      OP_INSERT: begin
        if (used_ext >= eff_cap) begin
          status_next = STAT_FULL;
        end else if (pos_q > used_ext) begin
          status_next = STAT_BAD_POS;
        end else begin
          apply_act = ACT_INSERT;
          used_next = CNT_W'(used_count + 1'b1);
        end
      end
      OP_ERASE_POS: begin
        if (used_count == '0) begin
          status_next = STAT_EMPTY;
        end else if (pos_q >= used_ext) begin
          status_next = STAT_BAD_POS;
        end else begin
          apply_act = ACT_ERASE_POS;
          used_next = CNT_W'(used_count - 1'b1);
        end
      end
      OP_ERASE_VAL: begin
        // cell 0 mark is the OR of all matches after the scan
        if (mark_ext[0]) begin
          apply_act = ACT_ERASE_VAL;
          used_next = CNT_W'(used_count - 1'b1);
        end else begin
          status_next = STAT_NOT_FOUND;
        end
      end
      default: ;  // unused opcode: report current count
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    ctrl.action = ACT_HOLD;
    ctrl.found  = mark_ext[0];
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (opcode == OP_ERASE_VAL) ? S_MARK : S_APPLY;
        end
      end
      S_MARK: begin
        ctrl.action = ACT_MARK;
        state_next  = S_SCAN;
      end
      S_SCAN: begin
        ctrl.action = ACT_SCAN;
        if (step == SW'(STEPS - 1)) begin
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        // wait for the result slot to free up before touching the cells
        if (out_free) begin
          ctrl.action = apply_act;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_SCAN) begin
      step <= SW'(step + 1'b1);
    end else begin
      step <= '0;
    end
  end

  // Count and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      used_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (apply_go) begin
        used_count <= used_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (apply_go) begin
      status_q <= status_next;
      count_q  <= COUNT_W'(used_next);
      empty_q  <= (used_next == '0);
    end
  end

  assign status   = status_q;
  assign count    = count_q;
  assign is_empty = empty_q;

  // Upper half of the mark vector stays zero so far taps never leave the row
  assign mark_ext[2*DEPTH-1:DEPTH] = '0;

  // Row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ENTRY_WIDTH-1:0] left_e;
    logic [ENTRY_WIDTH-1:0] right_e;
    logic                   far;

    if (i == 0) begin : g_first
      assign left_e = val_q;
    end else begin : g_mid_l
      assign left_e = cell_entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_e = cell_entry[i];
    end else begin : g_mid_r
      assign right_e = cell_entry[i+1];
    end

    // pick the mark 2^step slots above
    always_comb begin
      far = 1'b0;
      for (int k = 0; k < STEPS; k++) begin
        if (step == SW'(k)) begin
          far = mark_ext[i + (1 << k)];
        end
      end
    end

    ola_cell #(
      .IDX         (i),
      .CW          (CW),
      .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .position    (pos_q),
      .used        (used_ext),
      .value       (val_q),
      .left_entry  (left_e),
      .right_entry (right_e),
      .mark_far    (far),
      .mark_up     (mark_ext[i+1]),
      .entry       (cell_entry[i]),
      .mark        (mark_ext[i])
    );
  end

endmodule

@@ sv/ola_cell.sv @@
// One list slot: holds an entry and a match mark, shifts with its neighbors.
// Depends on ola_pkg.
`timescale 1ns / 1ps

module ola_cell
  import ola_pkg::*;
#(
  parameter int IDX         = 0,
  parameter int CW          = 5,
  parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF
) (
  input  logic                   clk,
  input  cell_ctrl_t             ctrl,
  input  logic [CW-1:0]          position,
  input  logic [CW-1:0]          used,
  input  logic [ENTRY_WIDTH-1:0] value,
  input  logic [ENTRY_WIDTH-1:0] left_entry,
  input  logic [ENTRY_WIDTH-1:0] right_entry,
  input  logic                   mark_far,
  input  logic                   mark_up,
  output logic [ENTRY_WIDTH-1:0] entry,
  output logic                   mark
);

  localparam logic [CW-1:0] IDX_C = CW'(IDX);

  logic                   occupied;
  logic [ENTRY_WIDTH-1:0] entry_next;
  logic                   mark_next;

  assign occupied = IDX_C < used;

  always_comb begin
    entry_next = entry;
    mark_next  = mark;
    case (ctrl.action)
      ACT_MARK: mark_next = occupied && (entry == value);
      // suffix OR, doubling the reach each step
      ACT_SCAN: mark_next = mark | mark_far;
      ACT_INSERT: begin
        if (IDX_C == position) begin
          entry_next = value;
        end else if (IDX_C > position && IDX_C <= used) begin
          entry_next = left_entry;
        end
      end
      ACT_ERASE_POS: begin
        if (IDX_C >= position) begin
          entry_next = right_entry;
        end
      end
      // at or above the last match when nothing above matches
      ACT_ERASE_VAL: begin
        if (ctrl.found && !mark_up) begin
          entry_next = right_entry;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
    mark  <= mark_next;
  end

endmodule
